[hw/rtl/tepm_pkg.sv]
package tepm_pkg;

   // Store sizing
   localparam int MAX_HITS  = 16;
   localparam int TIME_BITS = 20;
   localparam int CHAN_BITS = 5;
   localparam int KIND_BITS = 2;
   localparam int IDX_W     = $clog2(MAX_HITS);
   localparam int CNT_W     = $clog2(MAX_HITS + 1);

   // Command queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Edge kind codes on the request channel
   localparam logic [KIND_BITS-1:0] KIND_LEAD  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRAIL = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;

   typedef struct packed {
      logic [CHAN_BITS-1:0] chan_id;
      logic [KIND_BITS-1:0] edge_kind;
      logic [TIME_BITS-1:0] edge_time;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] out_chan;
      logic                 pair_valid;
      logic [TIME_BITS-1:0] lead_time;
      logic [TIME_BITS-1:0] trail_time;
      logic [TIME_BITS-1:0] pulse_width;
      logic                 dropped_edges;
      logic                 last_result;
   } rsp_type;

   // Classified command handed from front to back
   typedef enum logic [1:0] {
      CMD_LEAD,
      CMD_TRAIL,
      CMD_END
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [CHAN_BITS-1:0] chan;
      logic [TIME_BITS-1:0] etime;
   } cmd_type;

endpackage

[hw/rtl/tepm_front.sv]
module tepm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tepm_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output tepm_pkg::cmd_type cmd_data
);
   import tepm_pkg::*;

   cmd_type             q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                accept;
   logic                keep;
   logic                push;
   cmd_type             cmd_new;

   // Classify the beat; unused kinds are taken and dropped
   always_comb begin
      keep          = 1'b1;
      cmd_new.chan  = req_data.chan_id;
      cmd_new.etime = req_data.edge_time;
      cmd_new.op    = CMD_LEAD;
      unique case (req_data.edge_kind)
         KIND_LEAD:  cmd_new.op = CMD_LEAD;
         KIND_TRAIL: cmd_new.op = CMD_TRAIL;
         KIND_END:   cmd_new.op = CMD_END;
         default:    keep = 1'b0;
      endcase
   end

   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_mem[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(cmd_pop);
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[hw/rtl/tepm_back.sv]
module tepm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  tepm_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tepm_pkg::rsp_type rsp_data
);
   import tepm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_FIRST,
      ST_READ,
      ST_CMP,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     lead_cnt_ff, lead_cnt_in;
   logic [CNT_W-1:0]     trail_cnt_ff, trail_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [CHAN_BITS-1:0] chan_ff, chan_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [TIME_BITS-1:0] li_ff, li_in;
   logic                 pend_ff, pend_in;
   logic [TIME_BITS-1:0] pend_lead_ff, pend_lead_in;
   logic [TIME_BITS-1:0] pend_trail_ff, pend_trail_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [TIME_BITS-1:0] lead_mem  [MAX_HITS];
   logic [TIME_BITS-1:0] trail_mem [MAX_HITS];
   logic [TIME_BITS-1:0] lead_rd_ff;
   logic [TIME_BITS-1:0] trail_rd_ff;
   logic [IDX_W-1:0]     lead_addr;
   logic [IDX_W-1:0]     trail_addr;
   logic                 lead_we;
   logic                 trail_we;

   logic [CNT_W-1:0]     i_next;
   logic [CNT_W-1:0]     j_next;
   logic [CNT_W-1:0]     i_plus;
   logic                 adv_i;
   logic                 adv_j;
   logic                 hit;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign i_plus    = i_ff + CNT_W'(1);

   // Store read addresses: lead[0] at the start, then lead[i+1] and trail[j]
   assign lead_addr  = (state_ff == ST_PRIME) ? '0 : i_plus[IDX_W-1:0];
   assign trail_addr = j_ff[IDX_W-1:0];

   // Walk decision on lead[i], lead[i+1], trail[j]
   always_comb begin
      adv_i = 1'b0;
      adv_j = 1'b0;
      hit   = 1'b0;
      if (lead_rd_ff > trail_rd_ff) begin
         adv_i = 1'b1;
      end else if (trail_rd_ff > li_ff) begin
         adv_j = 1'b1;
      end else if (li_ff > trail_rd_ff) begin
         hit   = 1'b1;
         adv_i = 1'b1;
         adv_j = 1'b1;
      end else begin
         adv_i = 1'b1;
      end
      i_next = i_ff + CNT_W'(adv_i);
      j_next = j_ff + CNT_W'(adv_j);
   end

   // Next state and registered outputs
   always_comb begin
      state_in      = state_ff;
      lead_cnt_in   = lead_cnt_ff;
      trail_cnt_in  = trail_cnt_ff;
      ovf_in        = ovf_ff;
      chan_in       = chan_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      li_in         = li_ff;
      pend_in       = pend_ff;
      pend_lead_in  = pend_lead_ff;
      pend_trail_in = pend_trail_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      lead_we       = 1'b0;
      trail_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  CMD_LEAD: begin
                     if (lead_cnt_ff < CNT_W'(MAX_HITS)) begin
                        lead_we     = 1'b1;
                        lead_cnt_in = lead_cnt_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_TRAIL: begin
                     if (trail_cnt_ff < CNT_W'(MAX_HITS)) begin
                        trail_we     = 1'b1;
                        trail_cnt_in = trail_cnt_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_END: begin
                     chan_in = cmd_data.chan;
                     i_in    = '0;
                     j_in    = '0;
                     pend_in = 1'b0;
                     if ((lead_cnt_ff > CNT_W'(1)) && (trail_cnt_ff != '0)) begin
                        state_in = ST_PRIME;
                     end else begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PRIME: begin
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            // lead[0] arrives; lead[1] and trail[0] are being read
            li_in    = lead_rd_ff;
            state_in = ST_CMP;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!(hit && pend_ff && !out_free)) begin
               if (hit) begin
                  if (pend_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.out_chan    = chan_ff;
                     rsp_in.pair_valid  = 1'b1;
                     rsp_in.lead_time   = pend_lead_ff;
                     rsp_in.trail_time  = pend_trail_ff;
                     rsp_in.pulse_width = pend_lead_ff - pend_trail_ff;
                     rsp_in.dropped_edges = ovf_ff;
                     rsp_in.last_result = 1'b0;
                  end
                  pend_in       = 1'b1;
                  pend_lead_in  = li_ff;
                  pend_trail_in = trail_rd_ff;
               end
               if (adv_i) begin
                  li_in = lead_rd_ff;
               end
               i_in = i_next;
               j_in = j_next;
               if (((i_next + CNT_W'(1)) < lead_cnt_ff) && (j_next < trail_cnt_ff)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // The held pair, or an empty marker, closes the channel
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_chan      = chan_ff;
               rsp_in.pair_valid    = pend_ff;
               rsp_in.lead_time     = pend_ff ? pend_lead_ff : '0;
               rsp_in.trail_time    = pend_ff ? pend_trail_ff : '0;
               rsp_in.pulse_width   = pend_ff ? (pend_lead_ff - pend_trail_ff) : '0;
               rsp_in.dropped_edges = ovf_ff;
               rsp_in.last_result   = 1'b1;
               pend_in              = 1'b0;
               lead_cnt_in          = '0;
               trail_cnt_in         = '0;
               ovf_in               = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lead_cnt_ff  <= '0;
         trail_cnt_ff <= '0;
         ovf_ff       <= 1'b0;
         chan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lead_cnt_ff  <= lead_cnt_in;
         trail_cnt_ff <= trail_cnt_in;
         ovf_ff       <= ovf_in;
         chan_ff      <= chan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      li_ff         <= li_in;
      pend_lead_ff  <= pend_lead_in;
      pend_trail_ff <= pend_trail_in;
      rsp_ff        <= rsp_in;
   end

   // Edge stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (lead_we) begin
         lead_mem[lead_cnt_ff[IDX_W-1:0]] <= cmd_data.etime;
      end
      if (trail_we) begin
         trail_mem[trail_cnt_ff[IDX_W-1:0]] <= cmd_data.etime;
      end
      lead_rd_ff  <= lead_mem[lead_addr];
      trail_rd_ff <= trail_mem[trail_addr];
   end

   // Walk pointers stay inside the filled part of the stores
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (((i_ff + CNT_W'(1)) < lead_cnt_ff) && (j_ff < trail_cnt_ff)))
      else $error("walk pointer out of range");

   // A pair always has the leading time above the trailing time
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pair_valid) |-> (rsp_ff.lead_time > rsp_ff.trail_time))
      else $error("pair with non-positive width");

   // An empty result is only the closing beat of a channel
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.pair_valid) |-> rsp_ff.last_result)
      else $error("empty result not marked last");

   // Counts never pass the store depth
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      (lead_cnt_ff <= CNT_W'(MAX_HITS)) && (trail_cnt_ff <= CNT_W'(MAX_HITS)))
      else $error("edge count past store depth");

   // The counts are cleared once the closing beat is loaded
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (lead_cnt_ff == '0 && trail_cnt_ff == '0))
      else $error("stores not cleared after channel");

endmodule

[hw/rtl/tdc_edge_pair_matcher_core.sv]
// Edge beats are taken one per cycle into a 4-deep command queue while it is not full.
// An end marker walks the stores step by step (registered store read, then compare), at most
// lead_count + trail_count - 2 steps, after a start (prime, first read) and before a close (flush).
// With no walk it goes straight to the close; a full output register holds back the walk and close.
// Results leave through an output register, one pair held back to mark the last one.
// Reset (synchronous, active high) empties the queue and clears counts and overflow flag;
// store contents are not cleared and are only read once written.
module tdc_edge_pair_matcher_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tepm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tepm_pkg::rsp_type rsp_data
);
   import tepm_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   // Accept and classify beats
   tepm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // Store edges and run the pairing walk
   tepm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import tepm_pkg::*;

   // Kind code the block must ignore
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 410;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 150;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   tdc_edge_pair_matcher_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the edge stores
   logic [TIME_BITS-1:0] shadow_lead [MAX_HITS];
   logic [TIME_BITS-1:0] shadow_trail [MAX_HITS];
   int                   shadow_lead_cnt = 0;
   int                   shadow_trail_cnt = 0;
   logic                 shadow_overflow = 1'b0;
   logic [CHAN_BITS-1:0] shadow_chan = '0;

   rsp_type pending_pairs [$];

   int cycle_count = 0;
   int error_count = 0;
   int beats_sent = 0;
   int walks_done = 0;
   int pairs_seen = 0;
   int overflow_walks = 0;
   int results_checked = 0;
   int burst_left = 0;
   int stall_span = 0;
   logic [15:0] stall_pattern = '0;

   // Clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tdc_edge_pair_matcher_core test failed");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 60)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   // Shadow store update on every accepted beat, pairing walk on an end marker
   task automatic predict_pairs(input req_type beat);
      rsp_type found [MAX_HITS];
      rsp_type r;
      int i;
      int j;
      int n;
      shadow_chan = beat.chan_id;
      case (beat.edge_kind)
         KIND_LEAD: begin
            if (shadow_lead_cnt < MAX_HITS) begin
               shadow_lead[shadow_lead_cnt] = beat.edge_time;
               shadow_lead_cnt++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         KIND_TRAIL: begin
            if (shadow_trail_cnt < MAX_HITS) begin
               shadow_trail[shadow_trail_cnt] = beat.edge_time;
               shadow_trail_cnt++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         KIND_END: begin
            i = 0;
            j = 0;
            n = 0;
            while (i + 1 < shadow_lead_cnt && j < shadow_trail_cnt) begin
               if (shadow_lead[i+1] > shadow_trail[j]) begin
                  i++;
               end else if (shadow_trail[j] > shadow_lead[i]) begin
                  j++;
               end else if (shadow_lead[i] > shadow_trail[j]) begin
                  r.out_chan      = shadow_chan;
                  r.pair_valid    = 1'b1;
                  r.lead_time     = shadow_lead[i];
                  r.trail_time    = shadow_trail[j];
                  r.pulse_width   = shadow_lead[i] - shadow_trail[j];
                  r.dropped_edges = shadow_overflow;
                  r.last_result   = 1'b0;
                  if (n < MAX_HITS) begin
                     found[n] = r;
                     n++;
                  end
                  i++;
                  j++;
               end else begin
                  // tie: leading edge dropped
                  i++;
               end
            end
            if (n == 0) begin
               r.out_chan      = shadow_chan;
               r.pair_valid    = 1'b0;
               r.lead_time     = '0;
               r.trail_time    = '0;
               r.pulse_width   = '0;
               r.dropped_edges = shadow_overflow;
               r.last_result   = 1'b1;
               pending_pairs.push_back(r);
            end else begin
               found[n-1].last_result = 1'b1;
               for (i = 0; i < n; i++)
                  pending_pairs.push_back(found[i]);
            end
            walks_done++;
            pairs_seen += n;
            if (shadow_overflow)
               overflow_walks++;
            shadow_lead_cnt  = 0;
            shadow_trail_cnt = 0;
            shadow_overflow  = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Send one beat; the sender may idle between bursts of random length.
   // Entered and left at a falling edge.
   task automatic send_beat(input logic [CHAN_BITS-1:0] chan,
                            input logic [KIND_BITS-1:0] kind,
                            input logic [TIME_BITS-1:0] stamp);
      req_type beat;
      int gap;
      beat.chan_id   = chan;
      beat.edge_kind = kind;
      beat.edge_time = stamp;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_pairs(beat);
      if (kind != KIND_UNUSED)
         beats_sent++;
      @(negedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin : check_results
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (pending_pairs.size() == 0) begin
            report_error($sformatf("unexpected result chan %0d valid %0d",
                                   got.out_chan, got.pair_valid));
         end else begin
            want = pending_pairs.pop_front();
            results_checked++;
            if (got.out_chan != want.out_chan)
               report_error($sformatf("out_chan got %0d want %0d",
                                      got.out_chan, want.out_chan));
            if (got.pair_valid != want.pair_valid)
               report_error($sformatf("pair_valid got %0d want %0d",
                                      got.pair_valid, want.pair_valid));
            if (got.lead_time != want.lead_time)
               report_error($sformatf("lead_time got %0d want %0d",
                                      got.lead_time, want.lead_time));
            if (got.trail_time != want.trail_time)
               report_error($sformatf("trail_time got %0d want %0d",
                                      got.trail_time, want.trail_time));
            if (got.pulse_width != want.pulse_width)
               report_error($sformatf("pulse_width got %0d want %0d",
                                      got.pulse_width, want.pulse_width));
            if (got.dropped_edges != want.dropped_edges)
               report_error($sformatf("dropped_edges got %0d want %0d",
                                      got.dropped_edges, want.dropped_edges));
            if (got.last_result != want.last_result)
               report_error($sformatf("last_result got %0d want %0d",
                                      got.last_result, want.last_result));
         end
      end
   end

   // Receiver stall pattern: rotating 16-bit mask reloaded when stall_span runs out,
   // with bit 8 always clear so every stall run within a mask comes to an end
   initial begin
      forever begin
         @(negedge clock);
         if (stall_span == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom & $urandom);
               default: stall_pattern = 16'($urandom | $urandom);
            endcase
            stall_pattern[8] = 1'b0;
            stall_span = 48;
         end
         rsp_stall <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         stall_span--;
      end
   end

   // Empty channel and ignored kind
   task automatic test_empty_channel();
      send_beat(5'd31, KIND_END, TIME_MAX);
      send_beat(5'd5, KIND_UNUSED, TIME_MAX);
      send_beat(5'd10, KIND_END, '0);
      // a single leading edge is never paired
      send_beat(5'd3, KIND_LEAD, 20'd900);
      send_beat(5'd3, KIND_TRAIL, 20'd100);
      send_beat(5'd3, KIND_END, 20'd0);
   endtask

   // Tie, trailing advance and leading advance branches
   task automatic test_walk_branches();
      send_beat(5'd7, KIND_LEAD, 20'd200);
      send_beat(5'd7, KIND_LEAD, 20'd100);
      send_beat(5'd7, KIND_LEAD, 20'd50);
      send_beat(5'd7, KIND_TRAIL, 20'd200);
      send_beat(5'd7, KIND_TRAIL, 20'd60);
      send_beat(5'd7, KIND_END, 20'd0);
      send_beat(5'd21, KIND_LEAD, 20'd500);
      send_beat(5'd21, KIND_LEAD, 20'd400);
      send_beat(5'd21, KIND_LEAD, 20'd300);
      send_beat(5'd21, KIND_TRAIL, 20'd350);
      send_beat(5'd21, KIND_END, 20'd0);
   endtask

   // Widest pulse, mixed channel on an edge
   task automatic test_time_extremes();
      send_beat(5'd0, KIND_LEAD, TIME_MAX);
      send_beat(5'd31, KIND_LEAD, '0);
      send_beat(5'd0, KIND_TRAIL, '0);
      send_beat(5'd0, KIND_END, TIME_MAX);
   endtask

   // One channel of well-ordered pulses, times falling, some edges missing
   task automatic send_pulse_train(input int npulses);
      logic [CHAN_BITS-1:0] chan;
      int unsigned stamp;
      int unsigned width;
      int unsigned spacing;
      int k;
      chan  = 5'($urandom_range(0, 31));
      stamp = $urandom_range(200000, 1048575);
      for (k = 0; k < npulses; k++) begin
         width   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
         spacing = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4000);
         if ($urandom_range(0, 9) != 0)
            send_beat(($urandom_range(0, 15) == 0) ? 5'($urandom) : chan,
                      KIND_LEAD, 20'(stamp));
         stamp -= width;
         if ($urandom_range(0, 9) != 0)
            send_beat(chan, KIND_TRAIL, 20'(stamp));
         stamp -= spacing;
      end
      send_beat(chan, KIND_END, 20'($urandom));
   endtask

   // Arbitrary beats of every kind with full-range times
   task automatic send_noise(input int nbeats);
      int k;
      for (k = 0; k < nbeats; k++)
         send_beat(5'($urandom), 2'($urandom_range(0, 3)), 20'($urandom));
      send_beat(5'($urandom), KIND_END, 20'($urandom));
   endtask

   task automatic test_random_traffic();
      int pick;
      while (beats_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            if ($urandom_range(0, 6) == 0)
               send_pulse_train($urandom_range(14, 20));
            else
               send_pulse_train($urandom_range(0, 6));
         end else if (pick < 18) begin
            send_noise($urandom_range(1, 8));
         end else begin
            send_beat(5'($urandom), KIND_UNUSED, 20'($urandom));
            send_beat(5'($urandom), KIND_END, 20'($urandom));
         end
      end
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_channel();
      test_walk_branches();
      test_time_extremes();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d edge and marker beats over %0d channel walks (%0d with overflow)",
               beats_sent, walks_done, overflow_walks);
      $display("Checked %0d results, %0d of them matched pairs, %0d errors",
               results_checked, pairs_seen, error_count);
      if (error_count == 0) begin
         $display("tdc_edge_pair_matcher_core test passed");
      end else begin
         $display("tdc_edge_pair_matcher_core test failed");
      end
      $finish;
   end

endmodule
